// File: rtl/nbody_pair_accel_accumulate_assert.svh
// Assertion macros for the pair acceleration accumulator.
// Each macro samples on clk and is disabled while rst is high.
`ifndef NBODY_PAIR_ACCEL_ACCUMULATE_ASSERT_SVH
`define NBODY_PAIR_ACCEL_ACCUMULATE_ASSERT_SVH

// Same-cycle implication.
`define NBPA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nbpa assertion failed");

// Next-cycle implication.
`define NBPA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nbpa assertion failed");

`endif

// File: rtl/nbpa_pkg.sv
// Shared widths, codes and command/status types of the pair accelerator.
// No dependencies.
package nbpa_pkg;
  localparam int POS_W   = 32;
  localparam int WORD_W  = 32;
  localparam int ACC_W   = 48;
  localparam int ABS_W   = 33;
  localparam int SQ_W    = 66;
  localparam int ROOT_W  = 33;
  localparam int MA_W    = 66;
  localparam int MB_W    = 33;
  localparam int MP_W    = 99;
  localparam int GM_W    = 64;
  localparam int NUM_W   = 97;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOFTENING = 2'd1;

  localparam logic [WORD_W-1:0] GRAVITY_RESET   = 32'h0001_0000;
  localparam logic [WORD_W-1:0] SOFTENING_RESET = 32'h0001_0000;

  localparam logic [ACC_W-1:0] MAG_CAP = 48'h8000_0000_0000;

  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_MUL, OP_SQRT_INIT, OP_SQRT_STEP,
    OP_DIV_INIT, OP_DIV_STEP, OP_ACC, OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    MS_ADX2, MS_ADY2, MS_DD, MS_CUBE, MS_GM, MS_NX, MS_NY
  } mul_sel_t;

  typedef struct packed {
    op_t      op;
    mul_sel_t sel;
    logic     axis;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic last;
    logic out_busy;
  } status_t;
endpackage

// File: rtl/nbpa_if.sv
// Handshake channels of the pair accelerator: pair input and result output.
// Depends on nothing; widths follow the item fields.
interface nbpa_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [31:0] source_x;
  logic signed [31:0] source_y;
  logic        [31:0] source_mass;
  logic               last_source;

  modport source(output valid, target_x, target_y, source_x, source_y, source_mass,
                 last_source, input ready);
  modport sink(input valid, target_x, target_y, source_x, source_y, source_mass,
               last_source, output ready);
endinterface

interface nbpa_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] accel_x;
  logic signed [47:0] accel_y;
  logic               saturated;

  modport source(output valid, accel_x, accel_y, saturated, input ready);
  modport sink(input valid, accel_x, accel_y, saturated, output ready);
endinterface

// File: rtl/nbody_pair_accel_accumulate.sv
// Pair acceleration accumulator: one source body per pair beat; a last beat also
// loads the result register. Each pair runs seven 17-step multiplies, a 33-step root
// and two (24 + 2*FRAC_BITS)-step divisions, all sequenced one pair at a time.
// A finished result waits in an output register while the next pair runs.
// Synchronous reset clears sums, flag, result valid and registers G = softening = 1.0.
module nbody_pair_accel_accumulate #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [nbpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nbpa_pkg::WORD_W-1:0]    cfg_data,
  nbpa_in_if.sink                        pair,
  nbpa_out_if.source                     result
);
  import nbpa_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  nbpa_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pair.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  nbpa_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .target_x    (pair.target_x),
    .target_y    (pair.target_y),
    .source_x    (pair.source_x),
    .source_y    (pair.source_y),
    .source_mass (pair.source_mass),
    .last_source (pair.last_source),
    .accel_x     (result.accel_x),
    .accel_y     (result.accel_y),
    .saturated   (result.saturated),
    .out_valid   (result.valid),
    .out_ready   (result.ready)
  );

  assign pair.ready = in_ready;
endmodule

// File: rtl/nbpa_mul.sv
// Iterative shift-add multiplier, two multiplier bits per cycle.
// Depends on nbpa_pkg for operand and product widths.
module nbpa_mul (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [nbpa_pkg::MA_W-1:0] a,
  input  logic [nbpa_pkg::MB_W-1:0] b,
  output logic [nbpa_pkg::MP_W-1:0] product,
  output logic                      done
);
  import nbpa_pkg::*;

  localparam int STEPS = (MB_W + 1) / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic [MP_W-1:0]  areg;
  logic [MB_W-1:0]  breg;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [MP_W-1:0]  part;

  always_comb begin
    part = (breg[0] ? areg : '0) + (breg[1] ? {areg[MP_W-2:0], 1'b0} : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      if (cnt == CNT_W'(STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      areg    <= MP_W'(a);
      breg    <= b;
      product <= '0;
      cnt     <= '0;
    end else if (busy) begin
      product <= product + part;
      areg    <= {areg[MP_W-3:0], 2'b00};
      breg    <= {2'b00, breg[MB_W-1:2]};
      cnt     <= cnt + CNT_W'(1);
    end
  end
endmodule

// File: rtl/nbpa_datapath.sv
// Datapath: configuration, differences, square root and division steps,
// saturating accumulators and the result register. Uses nbpa_pkg, nbpa_mul.
module nbpa_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  nbpa_pkg::cmd_t                 cmd,
  output nbpa_pkg::status_t              status,
  input  logic                           cfg_we,
  input  logic [nbpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nbpa_pkg::WORD_W-1:0]    cfg_data,
  input  logic signed [31:0]             target_x,
  input  logic signed [31:0]             target_y,
  input  logic signed [31:0]             source_x,
  input  logic signed [31:0]             source_y,
  input  logic [31:0]                    source_mass,
  input  logic                           last_source,
  output logic signed [47:0]             accel_x,
  output logic signed [47:0]             accel_y,
  output logic                           saturated,
  output logic                           out_valid,
  input  logic                           out_ready
);
  import nbpa_pkg::*;

  localparam int DEN_W = 99 - 2 * FRAC_BITS;
  localparam int QW    = 24 + 2 * FRAC_BITS;
  localparam int SH    = 2 * FRAC_BITS - 24;
  localparam int SHR   = (SH >= 0) ? SH : 0;
  localparam int SHL   = (SH < 0) ? -SH : 0;
  localparam logic [QW-1:0] MAG_LIM = QW'(MAG_CAP >> SHL);
  localparam logic signed [ACC_W+1:0] SUM_HI = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [ACC_W+1:0] SUM_LO = -50'sh0_8000_0000_0000;

  logic [WORD_W-1:0] gravity_constant;
  logic [WORD_W-1:0] softening;

  logic [ABS_W-1:0]  adx, ady;
  logic              neg_x, neg_y;
  logic [WORD_W-1:0] mass;
  logic              last;
  logic [SQ_W-1:0]   s;
  logic [ROOT_W-1:0] root;
  logic [ROOT_W+1:0] sq_rem;
  logic [DEN_W-1:0]  den;
  logic [GM_W-1:0]   gm;
  logic [NUM_W-1:0]  num;
  logic [DEN_W-1:0]  dv_rem;
  logic [QW-1:0]     quo;
  logic              dv_ovf;
  logic signed [ACC_W-1:0] sum_x, sum_y;
  logic              sat_flag;
  mul_sel_t          mul_sel;

  // multiplier
  logic [MA_W-1:0] mul_a;
  logic [MB_W-1:0] mul_b;
  logic [MP_W-1:0] mul_p;
  logic            mul_done;

  nbpa_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.op == OP_MUL),
    .a       (mul_a),
    .b       (mul_b),
    .product (mul_p),
    .done    (mul_done)
  );

  always_comb begin
    mul_a = MA_W'(adx);
    mul_b = adx;
    case (cmd.sel)
      MS_ADX2: begin mul_a = MA_W'(adx);              mul_b = adx; end
      MS_ADY2: begin mul_a = MA_W'(ady);              mul_b = ady; end
      MS_DD:   begin mul_a = MA_W'(root);             mul_b = root; end
      MS_CUBE: begin mul_a = s;                       mul_b = root; end
      MS_GM:   begin mul_a = MA_W'(gravity_constant); mul_b = MB_W'(mass); end
      MS_NX:   begin mul_a = MA_W'(gm);               mul_b = adx; end
      MS_NY:   begin mul_a = MA_W'(gm);               mul_b = ady; end
      default: begin mul_a = '0;                      mul_b = '0; end
    endcase
  end

  // pair differences
  logic signed [ABS_W-1:0] dx, dy;
  always_comb begin
    dx = {target_x[31], target_x} - {source_x[31], source_x};
    dy = {target_y[31], target_y} - {source_y[31], source_y};
  end

  // denominator from the cube product
  logic [MP_W-1:0]  cube_sh;
  logic [DEN_W-1:0] den_sum;
  always_comb begin
    cube_sh = mul_p >> (2 * FRAC_BITS);
    den_sum = DEN_W'(cube_sh) + DEN_W'(softening);
  end

  // square root step
  logic [ROOT_W+3:0] sq_t, sq_trial;
  logic              sq_ge;
  always_comb begin
    sq_t     = {sq_rem, s[SQ_W-1:SQ_W-2]};
    sq_trial = (ROOT_W+4)'({root, 2'b01});
    sq_ge    = sq_t >= sq_trial;
  end

  // division init and step
  logic [NUM_W-1:0] rem0;
  logic [DEN_W:0]   dv_t;
  logic             dv_ge;
  always_comb begin
    rem0  = num >> QW;
    dv_t  = {dv_rem, num[QW-1]};
    dv_ge = dv_t >= {1'b0, den};
  end

  // term magnitude and saturating accumulate
  logic [QW-1:0]           qr;
  logic                    term_sat;
  logic [ACC_W-1:0]        mag;
  logic signed [ACC_W+1:0] acc_ext, mag_ext, sum_r;
  logic signed [ACC_W-1:0] sum_sat;
  logic                    acc_neg, clamp;
  always_comb begin
    qr       = quo >> SHR;
    term_sat = dv_ovf || (qr > MAG_LIM);
    mag      = term_sat ? MAG_CAP : (ACC_W'(qr) << SHL);
    acc_ext  = (cmd.axis == AXIS_Y) ? (ACC_W+2)'(sum_y) : (ACC_W+2)'(sum_x);
    acc_neg  = (cmd.axis == AXIS_Y) ? neg_y : neg_x;
    mag_ext  = signed'({2'b00, mag});
    sum_r    = acc_neg ? acc_ext + mag_ext : acc_ext - mag_ext;
    clamp    = 1'b0;
    if (sum_r > SUM_HI) begin
      sum_sat = SUM_HI[ACC_W-1:0];
      clamp   = 1'b1;
    end else if (sum_r < SUM_LO) begin
      sum_sat = SUM_LO[ACC_W-1:0];
      clamp   = 1'b1;
    end else begin
      sum_sat = sum_r[ACC_W-1:0];
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_constant <= GRAVITY_RESET;
      softening        <= SOFTENING_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRAVITY:   gravity_constant <= cfg_data;
        REG_SOFTENING: softening        <= cfg_data;
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        adx   <= dx[ABS_W-1] ? ABS_W'(-dx) : ABS_W'(dx);
        ady   <= dy[ABS_W-1] ? ABS_W'(-dy) : ABS_W'(dy);
        neg_x <= dx[ABS_W-1];
        neg_y <= dy[ABS_W-1];
        mass  <= source_mass;
        last  <= last_source;
      end
      OP_MUL: mul_sel <= cmd.sel;
      OP_SQRT_INIT: begin
        root   <= '0;
        sq_rem <= '0;
      end
      OP_SQRT_STEP: begin
        root   <= {root[ROOT_W-2:0], sq_ge};
        sq_rem <= sq_ge ? (ROOT_W+2)'(sq_t - sq_trial) : (ROOT_W+2)'(sq_t);
        s      <= {s[SQ_W-3:0], 2'b00};
      end
      OP_DIV_INIT: begin
        dv_ovf <= rem0 >= NUM_W'(den);
        dv_rem <= (rem0 >= NUM_W'(den)) ? '0 : DEN_W'(rem0);
        quo    <= '0;
      end
      OP_DIV_STEP: begin
        dv_rem <= dv_ge ? DEN_W'(dv_t - {1'b0, den}) : DEN_W'(dv_t);
        quo    <= {quo[QW-2:0], dv_ge};
        num    <= {num[NUM_W-2:0], 1'b0};
      end
      default: ;
    endcase

    // write back a finished product
    if (mul_done) begin
      case (mul_sel)
        MS_ADX2: s   <= mul_p[SQ_W-1:0];
        MS_ADY2: s   <= s + mul_p[SQ_W-1:0];
        MS_DD:   s   <= mul_p[SQ_W-1:0];
        MS_CUBE: den <= (den_sum == '0) ? DEN_W'(1) : den_sum;
        MS_GM:   gm  <= mul_p[GM_W-1:0];
        MS_NX:   num <= mul_p[NUM_W-1:0];
        MS_NY:   num <= mul_p[NUM_W-1:0];
        default: ;
      endcase
    end
  end

  // accumulators and result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x     <= '0;
      sum_y     <= '0;
      sat_flag  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_ACC) begin
        if (cmd.axis == AXIS_Y) sum_y <= sum_sat;
        else sum_x <= sum_sat;
        if (term_sat || clamp) sat_flag <= 1'b1;
      end
      if (cmd.op == OP_EMIT) begin
        sum_x     <= '0;
        sum_y     <= '0;
        sat_flag  <= 1'b0;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      accel_x   <= sum_x;
      accel_y   <= sum_y;
      saturated <= sat_flag;
    end
  end

  always_comb begin
    status.mul_done = mul_done;
    status.last     = last;
    status.out_busy = out_valid && !out_ready;
  end
endmodule

// File: rtl/nbpa_ctrl.sv
// Sequencer: walks each pair through products, root, divisions and
// accumulation. Uses nbpa_pkg and the assertion macro header.
`include "nbody_pair_accel_accumulate_assert.svh"
module nbpa_ctrl #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output nbpa_pkg::cmd_t    cmd,
  input  nbpa_pkg::status_t status
);
  import nbpa_pkg::*;

  localparam int QW    = 24 + 2 * FRAC_BITS;
  localparam int CNT_W = $clog2(QW);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_MWAIT  = 4'd2;
  localparam logic [3:0] S_SQINIT = 4'd3;
  localparam logic [3:0] S_SQRT   = 4'd4;
  localparam logic [3:0] S_DVINIT = 4'd5;
  localparam logic [3:0] S_DIV    = 4'd6;
  localparam logic [3:0] S_ACC    = 4'd7;
  localparam logic [3:0] S_EMIT   = 4'd8;

  logic [3:0]       state, state_next;
  mul_sel_t         mul_idx, mul_idx_next;
  logic             axis, axis_next;
  logic [CNT_W-1:0] step_cnt, step_cnt_next;

  always_comb begin
    state_next    = state;
    mul_idx_next  = mul_idx;
    axis_next     = axis;
    step_cnt_next = step_cnt;
    in_ready      = 1'b0;
    cmd.op        = OP_NOP;
    cmd.sel       = mul_idx;
    cmd.axis      = axis;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op       = OP_LOAD;
          mul_idx_next = MS_ADX2;
          state_next   = S_MUL;
        end
      end
      S_MUL: begin
        cmd.op     = OP_MUL;
        state_next = S_MWAIT;
      end
      S_MWAIT: begin
        if (status.mul_done) begin
          case (mul_idx)
            MS_ADX2: begin mul_idx_next = MS_ADY2; state_next = S_MUL; end
            MS_ADY2: state_next = S_SQINIT;
            MS_DD:   begin mul_idx_next = MS_CUBE; state_next = S_MUL; end
            MS_CUBE: begin mul_idx_next = MS_GM;   state_next = S_MUL; end
            MS_GM:   begin mul_idx_next = MS_NX;   state_next = S_MUL; end
            MS_NX:   begin axis_next = AXIS_X; state_next = S_DVINIT; end
            MS_NY:   begin axis_next = AXIS_Y; state_next = S_DVINIT; end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_SQINIT: begin
        cmd.op        = OP_SQRT_INIT;
        step_cnt_next = '0;
        state_next    = S_SQRT;
      end
      S_SQRT: begin
        cmd.op = OP_SQRT_STEP;
        if (step_cnt == CNT_W'(ROOT_W - 1)) begin
          mul_idx_next = MS_DD;
          state_next   = S_MUL;
        end else begin
          step_cnt_next = step_cnt + CNT_W'(1);
        end
      end
      S_DVINIT: begin
        cmd.op        = OP_DIV_INIT;
        step_cnt_next = '0;
        state_next    = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (step_cnt == CNT_W'(QW - 1)) state_next = S_ACC;
        else step_cnt_next = step_cnt + CNT_W'(1);
      end
      S_ACC: begin
        cmd.op = OP_ACC;
        if (axis == AXIS_X) begin
          mul_idx_next = MS_NY;
          state_next   = S_MUL;
        end else if (status.last) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        // hold until the result register frees up
        if (!status.out_busy) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      mul_idx <= MS_ADX2;
      axis    <= AXIS_X;
    end else begin
      state   <= state_next;
      mul_idx <= mul_idx_next;
      axis    <= axis_next;
    end
  end

  always_ff @(posedge clk) begin
    step_cnt <= step_cnt_next;
  end

  `NBPA_ASSERT_NXT(a_accept_starts, in_valid && in_ready, state == S_MUL && mul_idx == MS_ADX2)
  `NBPA_ASSERT_IMP(a_done_in_wait, status.mul_done, state == S_MWAIT)
  `NBPA_ASSERT_IMP(a_emit_free, cmd.op == OP_EMIT, !status.out_busy)
  `NBPA_ASSERT_IMP(a_sqrt_bound, state == S_SQRT, step_cnt < CNT_W'(ROOT_W))
endmodule

// File: bench/nbody_pair_accel_accumulate_tb.sv
// Self-checking bench for the 2D softened-gravity pair accumulator.
// Depends on nbpa_pkg, nbpa_if.sv and the nbody_pair_accel_accumulate RTL.
module testbench;
  import nbpa_pkg::*;

  localparam int FRAC = 16;
  localparam int ACC_FRAC = 24;
  localparam int DRAIN_CYCLES = 400;
  localparam int STALL_LIMIT = 6000;
  localparam logic signed [63:0] ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] ACC_LO = -64'sh0000_8000_0000_0000;

  typedef struct packed {
    logic [47:0] ax;
    logic [47:0] ay;
    logic        sat;
  } accel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_GRAVITY;
  logic [WORD_W-1:0] cfg_data = '0;

  nbpa_in_if  pair_if();
  nbpa_out_if res_if();

  nbody_pair_accel_accumulate #(.FRAC_BITS(FRAC)) u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .pair(pair_if), .result(res_if)
  );

  always #5 clk = ~clk;

  // model state
  logic [31:0] grav_q = GRAVITY_RESET;
  logic [31:0] soft_q = SOFTENING_RESET;
  logic signed [63:0] acc_x = 0, acc_y = 0;
  logic acc_sat = 1'b0;

  accel_t expected_accels[$];
  int errors = 0;
  int idle_cycles = 0;
  bit rx_no_stall = 1'b0;
  bit tx_no_gap = 1'b0;
  int rx_wait = 0;

  initial begin
    pair_if.valid = 1'b0;
    pair_if.target_x = '0;
    pair_if.target_y = '0;
    pair_if.source_x = '0;
    pair_if.source_y = '0;
    pair_if.source_mass = '0;
    pair_if.last_source = 1'b0;
    res_if.ready = 1'b0;
  end

  function automatic logic [63:0] floor_sqrt(logic [127:0] s);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= s) r = c;
    end
    return r[63:0];
  endfunction

  function automatic logic [63:0] pair_term(logic [63:0] gm, logic [63:0] ad,
                                            logic [127:0] den);
    logic [127:0] q;
    int sh;
    sh = 2 * FRAC - ACC_FRAC;
    q = ({64'd0, gm} * {64'd0, ad}) / den;
    if (sh >= 0) begin
      q = q >> sh;
      if (q > {80'd0, MAG_CAP}) begin
        acc_sat = 1'b1;
        return {16'd0, MAG_CAP};
      end
      return q[63:0];
    end
    if (q > ({80'd0, MAG_CAP} >> (-sh))) begin
      acc_sat = 1'b1;
      return {16'd0, MAG_CAP};
    end
    return q[63:0] << (-sh);
  endfunction

  function automatic logic signed [63:0] acc_update(logic signed [63:0] a, bit neg,
                                                    logic [63:0] mag);
    logic signed [63:0] r;
    r = neg ? a + $signed(mag) : a - $signed(mag);
    if (r > ACC_HI) begin
      acc_sat = 1'b1;
      return ACC_HI;
    end
    if (r < ACC_LO) begin
      acc_sat = 1'b1;
      return ACC_LO;
    end
    return r;
  endfunction

  task automatic predict_pair(logic [31:0] tx, logic [31:0] ty, logic [31:0] sx,
                              logic [31:0] sy, logic [31:0] m, logic last);
    logic signed [63:0] dx, dy;
    logic [63:0] adx, ady, d, gm;
    logic [127:0] den;
    accel_t e;
    dx = 64'($signed(tx)) - 64'($signed(sx));
    dy = 64'($signed(ty)) - 64'($signed(sy));
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    d = floor_sqrt({64'd0, adx} * adx + {64'd0, ady} * ady);
    den = (({64'd0, d} * d * d) >> (2 * FRAC)) + {96'd0, soft_q};
    if (den == 0) den = 1;
    gm = {32'd0, grav_q} * {32'd0, m};
    acc_x = acc_update(acc_x, dx < 0, pair_term(gm, adx, den));
    acc_y = acc_update(acc_y, dy < 0, pair_term(gm, ady, den));
    if (last) begin
      e.ax = acc_x[47:0];
      e.ay = acc_y[47:0];
      e.sat = acc_sat;
      expected_accels.push_back(e);
      acc_x = 0;
      acc_y = 0;
      acc_sat = 1'b0;
    end
  endtask

  task automatic send_pair(logic [31:0] tx, logic [31:0] ty, logic [31:0] sx,
                           logic [31:0] sy, logic [31:0] m, logic last);
    int gap;
    gap = tx_no_gap ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      pair_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pair_if.target_x <= tx;
    pair_if.target_y <= ty;
    pair_if.source_x <= sx;
    pair_if.source_y <= sy;
    pair_if.source_mass <= m;
    pair_if.last_source <= last;
    pair_if.valid <= 1'b1;
    do @(posedge clk); while (!(pair_if.valid && pair_if.ready));
    predict_pair(tx, ty, sx, sy, m, last);
  endtask

  // Hold off until all results are in and the block has finished any pair.
  task automatic wait_idle();
    pair_if.valid <= 1'b0;
    while (expected_accels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Drive one register write; the caller drops the write enable afterward.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == REG_GRAVITY) grav_q = val;
    else if (idx == REG_SOFTENING) soft_q = val;
  endtask

  task automatic set_config(logic [31:0] g, logic [31:0] s);
    wait_idle();
    write_reg(REG_GRAVITY, g);
    write_reg(REG_SOFTENING, s);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord(logic [31:0] base);
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return base + 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      2: return base + 32'($signed($urandom_range(0, 511)) - 256);
      default: return base + 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_mass();
    case ($urandom_range(0, 2))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0010_0000);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_pair(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 1'b1);
    send_pair(0, 0, 0, 32'h0002_0000, 32'h0004_0000, 1'b0);
    send_pair(32'h1234_5678, 32'h0abc_0000, 32'h1234_5678, 32'h0abc_0000,
              32'hffff_ffff, 1'b1);
    send_pair(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff,
              1'b0);
    send_pair(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 0, 1'b1);
  endtask

  task automatic test_zero_denominator();
    set_config(32'h0001_0000, 0);
    send_pair(32'h0000_0005, 0, 32'h0000_0004, 0, 32'h0001_0000, 1'b1);
    send_pair(0, 32'hffff_ffff, 0, 0, 32'hffff_ffff, 1'b0);
    send_pair(32'h0010_0000, 32'h0010_0000, 32'h0010_0000, 32'h0010_0000, 32'h1, 1'b1);
  endtask

  task automatic test_saturation();
    set_config(32'hffff_ffff, 0);
    send_pair(1, 0, 0, 1, 32'hffff_ffff, 1'b1);
    send_pair(0, 0, 32'h0000_0100, 32'hffff_ff00, 32'hffff_ffff, 1'b0);
    send_pair(0, 0, 32'h0000_0100, 32'hffff_ff00, 32'hffff_ffff, 1'b0);
    send_pair(0, 0, 32'hffff_ff00, 32'h0000_0100, 32'hffff_ffff, 1'b1);
    set_config(32'hffff_ffff, 32'hffff_ffff);
    send_pair(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff,
              1'b1);
    set_config(0, 32'hffff_ffff);
    send_pair(32'h0001_0000, 32'h0002_0000, 0, 0, 32'hffff_ffff, 1'b1);
  endtask

  task automatic run_random(int n_items);
    int sent;
    int run_len;
    logic [31:0] tx, ty;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: lone beat with random last flag
        send_pair($urandom, $urandom, $urandom, $urandom, $urandom,
                  1'($urandom_range(0, 1)));
        sent++;
      end else begin
        tx = $urandom;
        ty = $urandom;
        run_len = $urandom_range(1, 8);
        for (int i = 0; i < run_len; i++) begin
          if ($urandom_range(0, 15) == 0)
            send_pair(tx, ty, tx, ty, rand_mass(), i == run_len - 1);
          else
            send_pair(tx, ty, rand_coord(tx), rand_coord(ty), rand_mass(),
                      i == run_len - 1);
          sent++;
        end
      end
      if ($urandom_range(0, 40) == 0) tx_no_gap = ~tx_no_gap;
      if ($urandom_range(0, 40) == 0) rx_no_stall = ~rx_no_stall;
    end
  endtask

  task automatic test_random_configs();
    set_config(GRAVITY_RESET, SOFTENING_RESET);
    run_random(300);
    set_config($urandom, $urandom);
    run_random(300);
    set_config($urandom_range(0, 32'h0004_0000), $urandom_range(0, 3));
    run_random(300);
    set_config(32'hffff_ffff, 0);
    run_random(200);
    set_config(1, 32'hffff_ffff);
    run_random(190);
    set_config($urandom_range(0, 32'h0100_0000), $urandom_range(0, 32'h0100_0000));
    run_random(190);
  endtask

  // result sink: random stall before each beat unless rx_no_stall is set
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      rx_wait <= 0;
    end else if (res_if.valid && res_if.ready) begin
      if (expected_accels.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        accel_t e;
        e = expected_accels.pop_front();
        if (res_if.accel_x !== e.ax) begin
          $error("accel_x expected %h got %h", e.ax, res_if.accel_x);
          errors++;
        end
        if (res_if.accel_y !== e.ay) begin
          $error("accel_y expected %h got %h", e.ay, res_if.accel_y);
          errors++;
        end
        if (res_if.saturated !== e.sat) begin
          $error("saturated expected %b got %b", e.sat, res_if.saturated);
          errors++;
        end
      end
      if (rx_no_stall) begin
        res_if.ready <= 1'b1;
      end else begin
        automatic int w = $urandom_range(0, 15);
        rx_wait <= w;
        res_if.ready <= (w == 0);
      end
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      res_if.ready <= (rx_wait == 1);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((pair_if.valid && pair_if.ready) || (res_if.valid && res_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_zero_denominator();
    test_saturation();
    test_random_configs();
    wait_idle();
    if (errors == 0 && expected_accels.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
